// ===== sv/fmqd_pkg.sv =====
// ----------------------------------------------------------------------------
// fmqd_pkg
// Shared types and constants of the quarter-rate FM discriminator.
// ----------------------------------------------------------------------------
package fmqd_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_TAP_OUTER  = 3'd0;
	localparam logic [2:0] REG_TAP_SECOND = 3'd1;
	localparam logic [2:0] REG_TAP_THIRD  = 3'd2;
	localparam logic [2:0] REG_TAP_FOURTH = 3'd3;
	localparam logic [2:0] REG_TAP_CENTER = 3'd4;
	localparam logic [2:0] REG_OUT_GAIN   = 3'd5;

	// Widths of the datapath.
	localparam int SAMP_W = 17;
	localparam int ACC_W  = 40;
	localparam int CRD_W  = 44;

	// Arctangent table in 1/65536 turns.
	function automatic logic [15:0] atan_entry(input logic [4:0] idx);
		logic [15:0] r;
		begin
			case (idx)
				5'd0: r = 16'd8192;
				5'd1: r = 16'd4836;
				5'd2: r = 16'd2555;
				5'd3: r = 16'd1297;
				5'd4: r = 16'd651;
				5'd5: r = 16'd326;
				5'd6: r = 16'd163;
				5'd7: r = 16'd81;
				5'd8: r = 16'd41;
				5'd9: r = 16'd20;
				5'd10: r = 16'd10;
				5'd11: r = 16'd5;
				5'd12: r = 16'd3;
				5'd13: r = 16'd1;
				5'd14: r = 16'd1;
				default: r = 16'd0;
			endcase
			return r;
		end
	endfunction

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // take the sample, shift the delay lines
		logic clr_acc;    // clear the filter accumulators
		logic mac;        // one tap of multiply-accumulate
		logic crd_init;   // start the CORDIC from the accumulators
		logic crd_step;   // one CORDIC iteration
		logic scale;      // form the angle step and multiply by the gain
		logic finish;     // saturate into the output register
	} fmqd_cmd_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MAC   = 7'b0000010,
		ST_INIT  = 7'b0000100,
		ST_CRD   = 7'b0001000,
		ST_SCALE = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} fmqd_state_t;

endpackage

// ===== sv/fmqd_datapath.sv =====
// ----------------------------------------------------------------------------
// fmqd_datapath
// Mixer, delay lines, shared tap multiplier, iterative CORDIC and output gain.
// ----------------------------------------------------------------------------
module fmqd_datapath #(
	parameter int TAPS = 9,
	parameter int TAP_W = 4,
	parameter int STEP_W = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fmqd_pkg::fmqd_cmd_t      cmd,
	input  logic [TAP_W-1:0]         tap_idx,
	input  logic [STEP_W-1:0]        step_idx,
	input  logic signed [15:0]       sample,
	input  logic [15:0]              cfg_q [6],
	output logic signed [15:0]       demod
);
	import fmqd_pkg::*;

	logic [1:0]                 mix_phase_q;
	logic signed [SAMP_W-1:0]   i_delay_q [TAPS];
	logic signed [SAMP_W-1:0]   q_delay_q [TAPS];
	logic signed [ACC_W-1:0]    acc_i_q, acc_q_q;
	logic signed [CRD_W-1:0]    x_q, y_q;
	logic [15:0]                z_q;
	logic [15:0]                last_angle_q;
	logic signed [33:0]         prod_q;
	logic signed [15:0]         demod_q;

	logic signed [SAMP_W-1:0]   s_ext, iv, qv;
	logic signed [15:0]         coef;
	logic [TAP_W-1:0]           tap_dist;
	logic [2:0]                 coef_sel;
	logic signed [SAMP_W+15:0]  prod_i, prod_q_w;
	logic signed [CRD_W-1:0]    xs, ys, x0, y0;
	logic                       zero_vec;
	logic signed [15:0]         step;
	logic signed [33:0]         mag;
	logic signed [33:0]         quo;

	// Mixer by a quarter of the sample rate.
	always_comb begin
		s_ext = SAMP_W'(sample);
		iv = '0;
		qv = '0;
		case (mix_phase_q)
			2'd0: iv = s_ext;
			2'd1: qv = -s_ext;
			2'd2: iv = -s_ext;
			default: qv = s_ext;
		endcase
	end

	// Coefficient selection by distance from the nearer end of the line.
	always_comb begin
		if (tap_idx < TAP_W'(TAPS - 1) - tap_idx)
			tap_dist = tap_idx;
		else
			tap_dist = TAP_W'(TAPS - 1) - tap_idx;
		if (int'(tap_dist) > 4)
			coef_sel = REG_TAP_CENTER;
		else
			coef_sel = 3'(tap_dist);
		coef = cfg_q[coef_sel];
		prod_i   = i_delay_q[tap_idx] * coef;
		prod_q_w = q_delay_q[tap_idx] * coef;
	end

	// CORDIC pre-rotation and shifted terms.
	always_comb begin
		zero_vec = (acc_i_q == '0) && (acc_q_q == '0);
		x0 = CRD_W'(acc_i_q);
		y0 = CRD_W'(acc_q_q);
		xs = x_q >>> step_idx;
		ys = y_q >>> step_idx;
		step = $signed(z_q - last_angle_q);
		mag = (prod_q < 0) ? -prod_q : prod_q;
		quo = (prod_q < 0) ? -(mag >>> 16) : (mag >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_phase_q <= '0;
			last_angle_q <= '0;
			for (int t = 0; t < TAPS; t++) begin
				i_delay_q[t] <= '0;
				q_delay_q[t] <= '0;
			end
		end else begin
			if (cmd.load) begin
				mix_phase_q <= mix_phase_q + 2'd1;
				i_delay_q[0] <= iv;
				q_delay_q[0] <= qv;
				for (int t = 1; t < TAPS; t++) begin
					i_delay_q[t] <= i_delay_q[t-1];
					q_delay_q[t] <= q_delay_q[t-1];
				end
			end
			if (cmd.scale)
				last_angle_q <= z_q;
		end
	end

	// Accumulators, CORDIC registers and output scaling.
	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (cmd.mac) begin
			acc_i_q <= acc_i_q + ACC_W'(prod_i);
			acc_q_q <= acc_q_q + ACC_W'(prod_q_w);
		end
		if (cmd.crd_init) begin
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= 16'd32768;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (cmd.crd_step && !zero_vec) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_entry(5'(step_idx));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_entry(5'(step_idx));
			end
		end
		if (cmd.scale)
			prod_q <= 34'(step) * $signed({18'd0, cfg_q[5]});
		if (cmd.finish) begin
			if (quo > 34'sd32767)
				demod_q <= 16'sh7fff;
			else if (quo < -34'sd32768)
				demod_q <= 16'sh8000;
			else
				demod_q <= quo[15:0];
		end
	end

	assign demod = demod_q;

endmodule

// ===== sv/fmqd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmqd_ctrl
// Sequencer for one item: taps, CORDIC steps, scaling and output handshake.
// ----------------------------------------------------------------------------
module fmqd_ctrl #(
	parameter int TAPS = 9,
	parameter int CORDIC_STEPS = 16,
	parameter int TAP_W = 4,
	parameter int STEP_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fmqd_pkg::fmqd_cmd_t   cmd,
	output logic [TAP_W-1:0]      tap_idx,
	output logic [STEP_W-1:0]     step_idx
);
	import fmqd_pkg::*;

	fmqd_state_t state_q;
	logic [TAP_W-1:0]  tap_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign accept = (state_q == ST_IDLE) && in_valid;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign tap_idx = tap_q;
	assign step_idx = step_q;

	// Commands decoded from the state.
	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.clr_acc = accept;
		cmd.mac = (state_q == ST_MAC);
		cmd.crd_init = (state_q == ST_INIT);
		cmd.crd_step = (state_q == ST_CRD);
		cmd.scale = (state_q == ST_SCALE);
		cmd.finish = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MAC;
						tap_q <= '0;
					end
				end
				ST_MAC: begin
					if (tap_q == TAP_W'(TAPS - 1))
						state_q <= ST_INIT;
					else
						tap_q <= tap_q + TAP_W'(1);
				end
				ST_INIT: begin
					step_q <= '0;
					state_q <= ST_CRD;
				end
				ST_CRD: begin
					if (step_q == STEP_W'(CORDIC_STEPS - 1))
						state_q <= ST_SCALE;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_SCALE: state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/fm_quadrature_demodulator.sv =====
// An accepted sample passes through the states MAC, INIT, CRD, SCALE and FIN,
// and the result is held in OUT until taken; in_stall stays high until then, as
// the shared tap multiplier walks the delay line and the CORDIC runs one step per cycle.
// Reset clears the delay lines, mixer phase and previous angle, and loads the
// default coefficients and gain.
// ----------------------------------------------------------------------------
// fm_quadrature_demodulator
// FM discriminator: fs/4 mixer, symmetric lowpass, CORDIC angle, difference.
// ----------------------------------------------------------------------------
module fm_quadrature_demodulator #(
	parameter int TAPS = 9,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] demod,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import fmqd_pkg::*;

	localparam int TAP_W = $clog2(TAPS);
	localparam int STEP_W = $clog2(CORDIC_STEPS);

	logic [15:0] cfg_q [6];
	fmqd_cmd_t cmd;
	logic [TAP_W-1:0] tap_idx;
	logic [STEP_W-1:0] step_idx;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_TAP_OUTER] <= 16'hffce;
			cfg_q[REG_TAP_SECOND] <= 16'd903;
			cfg_q[REG_TAP_THIRD] <= 16'hf20b;
			cfg_q[REG_TAP_FOURTH] <= 16'd7295;
			cfg_q[REG_TAP_CENTER] <= 16'd23637;
			cfg_q[REG_OUT_GAIN] <= 16'd3142;
		end else if (cfg_we && cfg_index <= REG_OUT_GAIN) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	fmqd_ctrl #(
		.TAPS(TAPS), .CORDIC_STEPS(CORDIC_STEPS), .TAP_W(TAP_W), .STEP_W(STEP_W)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd),
		.tap_idx(tap_idx), .step_idx(step_idx)
	);

	fmqd_datapath #(
		.TAPS(TAPS), .TAP_W(TAP_W), .STEP_W(STEP_W)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .tap_idx(tap_idx),
		.step_idx(step_idx), .sample(sample), .cfg_q(cfg_q), .demod(demod)
	);

endmodule
